// File: design/akdf_pkg.sv
// Shared types, constants and AES functions for the key derivation block.
package akdf_pkg;

   localparam int BlockBits = 128;
   localparam int KeyBits   = 256;

   typedef enum logic [1:0] {
      OP_ABSORB   = 2'd0,
      OP_GENERATE = 2'd1,
      OP_RESTART  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_KEY_SIZE  = 3'd0,
      REG_KEY_WORD0 = 3'd1,
      REG_KEY_WORD1 = 3'd2,
      REG_KEY_WORD2 = 3'd3,
      REG_KEY_WORD3 = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      KEY_128 = 2'd0,
      KEY_192 = 2'd1,
      KEY_256 = 2'd2
   } key_size_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEYSTEP,
      ST_ROUND
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;       // capture item into the block register
      logic       key_init;   // restart the key schedule
      logic       key_step;   // advance the key schedule by one word
      logic       add_key;    // initial AddRoundKey
      logic       round;      // one AES round
      logic       last_round; // skip MixColumns
      logic       finish;     // write chain / result
      logic       restart;    // clear the chain
   } cmd_type;

   typedef struct packed {
      logic       rk_ready;   // four fresh round-key words available
   } status_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // One AES round body (SubBytes, ShiftRows, optional MixColumns), byte 0 in MSBs.
   function automatic logic [127:0] round_body(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[i + 4*c] = sbox(b[i + 4*((c + i) % 4)]);
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
      return r;
   endfunction

endpackage

// File: design/akdf_ctrl.sv
// Sequencer for key schedule and AES rounds.
module akdf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [4:0]           req_byte_count,
   input  logic [1:0]           key_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output akdf_pkg::cmd_type    cmd,
   input  akdf_pkg::status_type status
);
   import akdf_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic [3:0] nr;
   logic       gen_ff, gen_in;
   logic       rsp_pend_ff, rsp_pend_in;

   always_comb begin
      unique case (key_size)
         KEY_128: nr = 4'd10;
         KEY_192: nr = 4'd12;
         default: nr = 4'd14;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= '0;
         gen_ff      <= 1'b0;
         rsp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         gen_ff      <= gen_in;
         rsp_pend_ff <= rsp_pend_in;
      end
   end

   assign rsp_valid = rsp_pend_ff;

   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      gen_in      = gen_ff;
      rsp_pend_in = rsp_pend_ff && !rsp_ready;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_RESTART) begin
                  cmd.restart = 1'b1;
               end else if (req_op != OP_NONE && req_byte_count != 5'd0) begin
                  cmd.load     = 1'b1;
                  cmd.key_init = 1'b1;
                  gen_in       = (req_op == OP_GENERATE);
                  round_in     = 4'd0;
                  state_in     = ST_KEYSTEP;
               end
            end
         end
         ST_KEYSTEP: begin
            // Advance schedule until the next round key is complete.
            if (status.rk_ready) begin
               if (round_ff == 4'd0) cmd.add_key = 1'b1;
               else begin
                  cmd.round      = 1'b1;
                  cmd.last_round = (round_ff == nr);
               end
               if (round_ff == nr) begin
                  state_in = ST_ROUND;
               end else begin
                  round_in = round_ff + 4'd1;
               end
            end else begin
               cmd.key_step = 1'b1;
            end
         end
         ST_ROUND: begin
            // Hold a finished generate while the previous result still waits.
            if (!gen_ff || !rsp_pend_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               if (gen_ff) rsp_pend_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && gen_ff |-> !rsp_valid || rsp_ready)
      else $error("result overwritten");
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && gen_ff |=> rsp_valid)
      else $error("bad finish");
endmodule

// File: design/akdf_datapath.sv
// Key schedule, AES round unit, chain and result registers.
module akdf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  akdf_pkg::cmd_type    cmd,
   output akdf_pkg::status_type status,
   input  logic [1:0]           key_size,
   input  logic [255:0]         key,
   input  logic [1:0]           req_op,
   input  logic [63:0]          req_data_hi,
   input  logic [63:0]          req_data_lo,
   input  logic [4:0]           req_byte_count,
   output logic [63:0]          rsp_out_hi,
   output logic [63:0]          rsp_out_lo,
   output logic [4:0]           rsp_valid_bytes
);
   import akdf_pkg::*;

   logic [127:0] chain_ff, chain_in;
   logic [127:0] blk_ff, blk_in;
   logic [4:0]   n_ff, n_in;
   logic         gen_ff, gen_in;
   logic [127:0] out_ff, out_in;
   logic [4:0]   vb_ff, vb_in;
   // Sliding window of the last eight schedule words, newest at index 7.
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [3:0]   nk;
   logic [5:0]   widx_ff, widx_in;   // index of next word to produce
   logic [5:0]   used_ff, used_in;   // words consumed by rounds so far
   logic [2:0]   pos_ff, pos_in;     // i mod nk
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  w, tmp;
   logic [127:0] rk, mask, pad, inc, enc;

   always_comb begin
      unique case (key_size)
         KEY_128: nk = 4'd4;
         KEY_192: nk = 4'd6;
         default: nk = 4'd8;
      endcase
   end

   // Round key = the four oldest unconsumed words held in the window.
   assign status.rk_ready = (widx_ff - used_ff) >= 6'd4;
   always_comb begin
      logic [2:0] b;
      b  = 3'(6'd8 - (widx_ff - used_ff));
      rk = {win_ff[b], win_ff[3'(b + 3'd1)], win_ff[3'(b + 3'd2)], win_ff[3'(b + 3'd3)]};
   end

   always_comb begin
      w = win_ff[7];
      if (pos_ff == 3'd0)
         tmp = sub_word({w[23:0], w[31:24]}) ^ {rcon_ff, 24'h0};
      else if (nk == 4'd8 && pos_ff == 3'd4)
         tmp = sub_word(w);
      else
         tmp = w;
      tmp = tmp ^ win_ff[3'(4'd8 - nk)];
   end

   always_comb begin
      for (int i = 0; i < 16; i++)
         mask[127 - 8*i -: 8] = (5'(i) < req_byte_count) ? 8'hff : 8'h00;
      pad = {req_data_hi, req_data_lo} & mask;
      inc = chain_ff + 128'd1;
   end

   always_comb begin
      win_in  = win_ff;
      widx_in = widx_ff;
      used_in = used_ff;
      pos_in  = pos_ff;
      rcon_in = rcon_ff;
      blk_in  = blk_ff;
      n_in    = n_ff;
      gen_in  = gen_ff;
      chain_in = chain_ff;
      out_in  = out_ff;
      vb_in   = vb_ff;
      enc     = blk_ff;
      if (cmd.key_init) begin
         for (int i = 0; i < 8; i++) win_in[i] = '0;
         // Right-align the nk key words in the window.
         for (int i = 0; i < 8; i++)
            if (4'(i) < nk) win_in[3'(4'd8 - nk + 4'(i))] = key[255 - 32*i -: 32];
         widx_in = 6'(nk);
         used_in = '0;
         pos_in  = '0;
         rcon_in = 8'h01;
         n_in    = (req_byte_count > 5'd16) ? 5'd16 : req_byte_count;
         gen_in  = (req_op == OP_GENERATE);
         blk_in  = (req_op == OP_GENERATE) ? inc : (chain_ff ^ pad);
         if (req_op == OP_GENERATE) chain_in = inc;
      end
      if (cmd.key_step) begin
         for (int i = 0; i < 7; i++) win_in[i] = win_ff[i+1];
         win_in[7] = tmp;
         widx_in   = widx_ff + 6'd1;
         if (pos_ff == 3'(nk - 4'd1)) begin
            pos_in  = '0;
         end else pos_in = pos_ff + 3'd1;
         if (pos_ff == 3'd0) rcon_in = xtime(rcon_ff);
      end
      if (cmd.add_key) begin
         blk_in  = blk_ff ^ rk;
         used_in = used_ff + 6'd4;
      end
      if (cmd.round) begin
         blk_in  = round_body(blk_ff, !cmd.last_round) ^ rk;
         used_in = used_ff + 6'd4;
      end
      if (cmd.finish) begin
         // Absorb always takes the cipher block; a full generate keeps the counter.
         if (gen_ff) begin
            for (int i = 0; i < 16; i++)
               out_in[127 - 8*i -: 8] = (5'(i) < n_ff) ? enc[127 - 8*i -: 8] : 8'h00;
            vb_in = n_ff;
         end
         if (!gen_ff || n_ff != 5'd16) chain_in = enc;
      end
      if (cmd.restart) chain_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
      blk_ff  <= blk_in;
      n_ff    <= n_in;
      gen_ff  <= gen_in;
      out_ff  <= out_in;
      vb_ff   <= vb_in;
      win_ff  <= win_in;
      widx_ff <= widx_in;
      used_ff <= used_in;
      pos_ff  <= pos_in;
      rcon_ff <= rcon_in;
   end

   assign rsp_out_hi      = out_ff[127:64];
   assign rsp_out_lo      = out_ff[63:0];
   assign rsp_valid_bytes = vb_ff;
endmodule

// File: design/aes_chained_absorb_counter_kdf_top.sv
// Top level of the AES chained-absorb counter key derivation block.
// Each absorb or generate word runs one AES encryption with an on-the-fly key
// schedule: the schedule produces one 32-bit word per cycle while no round key
// is ready, and the round unit does one round per cycle once four fresh words
// are present. A new word is accepted only once the previous one is finished.
// The ST_ROUND finish step after the last round writes a generate result into
// the output register. Restart words are handled while idle and clear the
// chain. A generate result waits in the output register until taken while the
// next word is accepted and processed; a further generate holds in ST_ROUND
// until the waiting result is taken. Key registers are written over csr_; the
// user must write them only while idle, as the block does not enforce this.
module aes_chained_absorb_counter_kdf_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_hi,
   output logic [63:0] rsp_out_lo,
   output logic [4:0]  rsp_valid_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import akdf_pkg::*;

   logic [1:0]  key_size_ff;
   logic [63:0] key_ff [4];
   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   // Hold key registers; update on a csr word.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KEY_SIZE:  key_size_ff <= csr_data[1:0];
            REG_KEY_WORD0: key_ff[0] <= csr_data;
            REG_KEY_WORD1: key_ff[1] <= csr_data;
            REG_KEY_WORD2: key_ff[2] <= csr_data;
            REG_KEY_WORD3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   akdf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_byte_count,
      .key_size(key_size_ff), .rsp_valid, .rsp_ready, .cmd, .status
   );

   akdf_datapath u_dp (
      .clock, .reset, .cmd, .status, .key_size(key_size_ff),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .req_op, .req_data_hi, .req_data_lo, .req_byte_count,
      .rsp_out_hi, .rsp_out_lo, .rsp_valid_bytes
   );
endmodule
